// File: src/mm_pkg.sv
`timescale 1ns / 1ps

package mm_pkg;

	localparam int unsigned VAL_W     = 32;
	localparam int unsigned PROD_W    = 64;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned FIELD_W   = 2;
	localparam int unsigned DIM_REG_W = 3;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned TDATA_W   = 40;
	localparam int unsigned DEF_MAX_DIM = 4;

	localparam logic [DIM_REG_W-1:0] DIM_RESET = 3'd4;

	localparam logic [FIELD_W-1:0] MODE_LOAD_A = 2'd0;
	localparam logic [FIELD_W-1:0] MODE_LOAD_B = 2'd1;
	localparam logic [FIELD_W-1:0] MODE_START  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd2;

	localparam logic [VAL_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] SAT_MIN = 32'h8000_0000;

	// control tag that travels with each multiply-accumulate term
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} mac_ctl_t;

	// zero counts as one, anything above the array size saturates to it
	function automatic logic [3:0] clamp_dim(logic [DIM_REG_W-1:0] v, int unsigned maxd);
		logic [3:0] res;
		if (v == '0) begin
			res = 4'd1;
		end else if (32'(v) > maxd) begin
			res = 4'(maxd);
		end else begin
			res = {1'b0, v};
		end
		return res;
	endfunction

endpackage

// File: src/mm_store.sv
`timescale 1ns / 1ps

module mm_store #(
	parameter int unsigned MAX_DIM = mm_pkg::DEF_MAX_DIM,
	parameter int unsigned AW      = 4
) (
	input  logic                     clk,
	input  logic                     we_a,
	input  logic                     we_b,
	input  logic [AW-1:0]            waddr,
	input  logic [mm_pkg::VAL_W-1:0] wdata,
	input  logic [AW-1:0]            raddr_a,
	input  logic [AW-1:0]            raddr_b,
	output logic [mm_pkg::VAL_W-1:0] rdata_a,
	output logic [mm_pkg::VAL_W-1:0] rdata_b
);
	import mm_pkg::*;

	localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;

	logic [VAL_W-1:0] mem_a [DEPTH];
	logic [VAL_W-1:0] mem_b [DEPTH];

	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[waddr] <= wdata;
		end
		rdata_a <= mem_a[raddr_a];
	end

	always_ff @(posedge clk) begin
		if (we_b) begin
			mem_b[waddr] <= wdata;
		end
		rdata_b <= mem_b[raddr_b];
	end

endmodule

// File: src/mm_mac.sv
`timescale 1ns / 1ps

module mm_mac #(
	parameter int unsigned MAX_DIM = mm_pkg::DEF_MAX_DIM
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mm_pkg::mac_ctl_t                ctl,
	input  logic signed [mm_pkg::VAL_W-1:0] rdata_a,
	input  logic signed [mm_pkg::VAL_W-1:0] rdata_b,
	output logic                            done,
	output logic [mm_pkg::VAL_W-1:0]        result
);
	import mm_pkg::*;

	localparam int unsigned ACC_W = PROD_W + $clog2(MAX_DIM) + 1;
	localparam int unsigned TOP_W = ACC_W - (VAL_W + FRAC_W) + 1;

	mac_ctl_t                  ctl_s1;
	mac_ctl_t                  ctl_s2;
	logic signed [PROD_W-1:0]  product_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   term;
	logic                      done_q;
	logic [TOP_W-1:0]          top_bits;
	logic                      fits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.vld & ctl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		product_s2 <= rdata_a * rdata_b;
	end

	assign term = {{(ACC_W-PROD_W){product_s2[PROD_W-1]}}, product_s2};

	always_ff @(posedge clk) begin
		if (ctl_s2.vld) begin
			acc_q <= ctl_s2.first ? term : acc_q + term;
		end
	end

	// the shifted sum fits when every bit from bit 47 up equals the sign
	assign top_bits = acc_q[ACC_W-1:VAL_W+FRAC_W-1];
	assign fits     = (&top_bits) | ~(|top_bits);

	always_comb begin
		if (fits) begin
			result = acc_q[VAL_W+FRAC_W-1:FRAC_W];
		end else if (acc_q[ACC_W-1]) begin
			result = SAT_MIN;
		end else begin
			result = SAT_MAX;
		end
	end

	assign done = done_q;

endmodule

// File: src/matrix_multiply_top.sv
`timescale 1ns / 1ps
// Load items (A or B element) are accepted back to back, one per cycle while idle; ready is high only in idle.
// A start item emits rows_a * cols_b results (dimensions clamped); each result is built in order:
// inner_size reads through the one shared multiplier, a drain through the pipeline registers, one push.
// The push waits until the output register is free; the block is not ready
// until the final result is loaded into the output register.
// Reset clears control state and sets each dimension register to 4; stores are not cleared.
module matrix_multiply_top #(
	parameter int unsigned MAX_DIM = mm_pkg::DEF_MAX_DIM
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [1:0] row_index, [3:2] col_index, [35:4] element_value, [39:36] zero
	input  logic [mm_pkg::TDATA_W-1:0]    s_tdata,
	// [1:0] mode
	input  logic [mm_pkg::FIELD_W-1:0]    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [1:0] out_row, [3:2] out_col, [35:4] product_value, [39:36] zero
	output logic [mm_pkg::TDATA_W-1:0]    m_tdata,
	output logic                          m_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mm_pkg::DIM_REG_W-1:0]  cfg_data
);
	import mm_pkg::*;

	localparam int unsigned IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_DIM + 1);
	localparam int unsigned AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_PUSH  = 4'b1000
	} state_t;

	state_t                state_q;
	logic [DIM_REG_W-1:0]  rows_a_q;
	logic [DIM_REG_W-1:0]  inner_size_q;
	logic [DIM_REG_W-1:0]  cols_b_q;
	logic [CNT_W-1:0]      nr_q;
	logic [CNT_W-1:0]      nk_q;
	logic [CNT_W-1:0]      nc_q;
	logic [IDX_W-1:0]      r_q;
	logic [IDX_W-1:0]      c_q;
	logic [IDX_W-1:0]      k_q;

	logic                  out_valid_q;
	logic [FIELD_W-1:0]    out_row_q;
	logic [FIELD_W-1:0]    out_col_q;
	logic [VAL_W-1:0]      out_value_q;
	logic                  out_last_q;

	logic                  in_acc;
	logic [FIELD_W-1:0]    in_row;
	logic [FIELD_W-1:0]    in_col;
	logic [VAL_W-1:0]      in_value;
	logic                  in_range;
	logic                  we_a;
	logic                  we_b;
	logic [AW-1:0]         waddr;
	logic [AW-1:0]         raddr_a;
	logic [AW-1:0]         raddr_b;
	logic [VAL_W-1:0]      rdata_a;
	logic [VAL_W-1:0]      rdata_b;
	logic                  k_last;
	logic                  r_last;
	logic                  c_last;
	logic                  out_free;
	logic                  mac_done;
	logic [VAL_W-1:0]      mac_result;
	mac_ctl_t              mac_ctl;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid & s_tready;
	assign in_row    = s_tdata[1:0];
	assign in_col    = s_tdata[3:2];
	assign in_value  = s_tdata[35:4];

	assign in_range = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
	assign we_a     = in_acc && (s_tuser == MODE_LOAD_A) && in_range;
	assign we_b     = in_acc && (s_tuser == MODE_LOAD_B) && in_range;
	assign waddr    = AW'(32'(in_row) * MAX_DIM + 32'(in_col));
	assign raddr_a  = AW'(32'(r_q) * MAX_DIM + 32'(k_q));
	assign raddr_b  = AW'(32'(k_q) * MAX_DIM + 32'(c_q));

	assign k_last   = ((CNT_W'(k_q) + CNT_W'(1)) == nk_q);
	assign r_last   = ((CNT_W'(r_q) + CNT_W'(1)) == nr_q);
	assign c_last   = ((CNT_W'(c_q) + CNT_W'(1)) == nc_q);
	assign out_free = ~out_valid_q | m_tready;

	assign mac_ctl.vld   = (state_q == ST_ISSUE);
	assign mac_ctl.first = (k_q == '0);
	assign mac_ctl.last  = k_last;

	mm_store #(
		.MAX_DIM (MAX_DIM),
		.AW      (AW)
	) u_store (
		.clk     (clk),
		.we_a    (we_a),
		.we_b    (we_b),
		.waddr   (waddr),
		.wdata   (in_value),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	mm_mac #(
		.MAX_DIM (MAX_DIM)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b),
		.done    (mac_done),
		.result  (mac_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q     <= DIM_RESET;
			inner_size_q <= DIM_RESET;
			cols_b_q     <= DIM_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ROWS_A:     rows_a_q     <= cfg_data;
				CFG_INNER_SIZE: inner_size_q <= cfg_data;
				CFG_COLS_B:     cols_b_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nr_q    <= '0;
			nk_q    <= '0;
			nc_q    <= '0;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (s_tuser == MODE_START)) begin
						nr_q    <= CNT_W'(clamp_dim(rows_a_q, MAX_DIM));
						nk_q    <= CNT_W'(clamp_dim(inner_size_q, MAX_DIM));
						nc_q    <= CNT_W'(clamp_dim(cols_b_q, MAX_DIM));
						r_q     <= '0;
						c_q     <= '0;
						k_q     <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (k_last) begin
						k_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (mac_done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						if (c_last) begin
							c_q <= '0;
							r_q <= r_q + IDX_W'(1);
							state_q <= r_last ? ST_IDLE : ST_ISSUE;
						end else begin
							c_q     <= c_q + IDX_W'(1);
							state_q <= ST_ISSUE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register: hold until taken, reload in the same cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_PUSH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_PUSH) && out_free) begin
			out_row_q   <= FIELD_W'(r_q);
			out_col_q   <= FIELD_W'(c_q);
			out_value_q <= mac_result;
			out_last_q  <= r_last & c_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(TDATA_W - VAL_W - 2 * FIELD_W){1'b0}}, out_value_q, out_col_q,
			out_row_q};

endmodule

// File: tb/sv/matrix_multiply_checker.sv
`timescale 1ns / 1ps

module matrix_multiply_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	// [1:0] row_index, [3:2] col_index, [35:4] element_value, [39:36] zero
	input  logic [mm_pkg::TDATA_W-1:0]   s_tdata,
	// [1:0] mode
	input  logic [mm_pkg::FIELD_W-1:0]   s_tuser,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	// [1:0] out_row, [3:2] out_col, [35:4] product_value, [39:36] zero
	input  logic [mm_pkg::TDATA_W-1:0]   m_tdata,
	input  logic                         m_tlast,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [mm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mm_pkg::DIM_REG_W-1:0] cfg_data,
	output int                           errors,
	output int                           outstanding,
	output int                           products_checked
);
	import mm_pkg::*;

	localparam int MAX_DIM = DEF_MAX_DIM;
	localparam logic signed [79:0] POS_LIMIT = 80'sd2147483647;
	localparam logic signed [79:0] NEG_LIMIT = -80'sd2147483648;

	typedef struct packed {
		logic [FIELD_W-1:0] row;
		logic [FIELD_W-1:0] col;
		logic [VAL_W-1:0]   value;
		logic               last;
	} product_t;

	product_t             pending_products[$];
	product_t             want;
	logic [VAL_W-1:0]     a_elems [MAX_DIM][MAX_DIM];
	logic [VAL_W-1:0]     b_elems [MAX_DIM][MAX_DIM];
	logic [DIM_REG_W-1:0] rows_reg, inner_reg, cols_reg;
	int                   fail_cnt, seen_cnt;
	int                   nr, nk, nc;

	function automatic int dim_in_use(logic [DIM_REG_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (int'(v) > MAX_DIM) begin
			return MAX_DIM;
		end
		return int'(v);
	endfunction

	// full-width sum of Q16.16 products, rescaled by truncation, clipped to 32 bits
	function automatic logic [VAL_W-1:0] dot_q16(int r, int c, int n);
		logic signed [79:0] acc;
		logic signed [63:0] term;
		logic signed [79:0] scaled;
		acc = '0;
		for (int k = 0; k < n; k++) begin
			term = $signed(a_elems[r][k]) * $signed(b_elems[k][c]);
			acc = acc + term;
		end
		scaled = acc >>> FRAC_W;
		if (scaled > POS_LIMIT) begin
			return SAT_MAX;
		end
		if (scaled < NEG_LIMIT) begin
			return SAT_MIN;
		end
		return scaled[VAL_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg = DIM_RESET;
			inner_reg = DIM_RESET;
			cols_reg = DIM_RESET;
			pending_products.delete();
			fail_cnt = 0;
			seen_cnt = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_products.size() == 0) begin
					$display("%0t: unexpected product row %0d col %0d value %h last %b",
						$time, m_tdata[1:0], m_tdata[3:2], m_tdata[35:4], m_tlast);
					fail_cnt++;
				end else begin
					want = pending_products.pop_front();
					seen_cnt++;
					if (m_tdata[1:0] !== want.row || m_tdata[3:2] !== want.col ||
						m_tdata[35:4] !== want.value || m_tlast !== want.last) begin
						$display("%0t: product mismatch, expected row %0d col %0d value %h last %b",
							$time, want.row, want.col, want.value, want.last);
						$display("%0t:                   got row %0d col %0d value %h last %b",
							$time, m_tdata[1:0], m_tdata[3:2], m_tdata[35:4], m_tlast);
						fail_cnt++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ROWS_A: rows_reg = cfg_data;
					CFG_INNER_SIZE: inner_reg = cfg_data;
					CFG_COLS_B: cols_reg = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					MODE_LOAD_A: a_elems[s_tdata[1:0]][s_tdata[3:2]] = s_tdata[35:4];
					MODE_LOAD_B: b_elems[s_tdata[1:0]][s_tdata[3:2]] = s_tdata[35:4];
					MODE_START: begin
						nr = dim_in_use(rows_reg);
						nk = dim_in_use(inner_reg);
						nc = dim_in_use(cols_reg);
						for (int r = 0; r < nr; r++) begin
							for (int c = 0; c < nc; c++) begin
								want.row = FIELD_W'(r);
								want.col = FIELD_W'(c);
								want.value = dot_q16(r, c, nk);
								want.last = (r == nr - 1) && (c == nc - 1);
								pending_products.push_back(want);
							end
						end
					end
					default: ;
				endcase
			end
		end
		errors <= fail_cnt;
		outstanding <= pending_products.size();
		products_checked <= seen_cnt;
	end

endmodule

// File: tb/sv/matrix_multiply_top_test.sv
`timescale 1ns / 1ps

module matrix_multiply_top_test;
	import mm_pkg::*;

	localparam logic [FIELD_W-1:0]   MODE_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
	localparam int NUM_PHASES     = 11;
	localparam int PHASE_ITEMS    = 38;
	localparam int HOLD_PHASE     = 5;
	localparam int STEADY_PHASE   = 7;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 10;
	localparam int DRAIN_CYCLES   = 30;
	localparam int WATCHDOG_LIMIT = 5000;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata;
	logic [FIELD_W-1:0]   s_tuser;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic                 m_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_REG_W-1:0] cfg_data;

	int errors, outstanding, products_checked;
	int loads_sent, starts_sent, ignored_sent, settings_used;
	int sent, pick, quiet_cycles;
	int hold_cnt = 0;
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit hold_req = 1'b0;
	logic [FIELD_W-1:0]   mode;
	logic [DIM_REG_W-1:0] dim_r, dim_k, dim_c;

	matrix_multiply_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	matrix_multiply_checker product_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.outstanding(outstanding),
		.products_checked(products_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// result sink: a long hold-off on request, otherwise random stalls
	always @(posedge clk) begin
		if (hold_req && hold_cnt < HOLD_CYCLES) begin
			hold_cnt <= hold_cnt + 1;
			m_tready <= 1'b0;
		end else begin
			if (!hold_req) begin
				hold_cnt <= 0;
			end
			m_tready <= !rx_gaps || ($urandom_range(99) >= 31);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
			$display("matrix_multiply_top_test NOT OK");
			$finish;
		end
	end

	// mostly values that keep the sums in range, some full scale and corner values
	function automatic logic [VAL_W-1:0] elem_value();
		logic [VAL_W-1:0] r;
		r = $urandom;
		case ($urandom_range(3))
			0: return r;
			1: return {{14{r[17]}}, r[17:0]};
			2: return {{7{r[24]}}, r[24:0]};
			default: begin
				case ($urandom_range(5))
					0: return SAT_MAX;
					1: return SAT_MIN;
					2: return '0;
					3: return '1;
					4: return 32'd1;
					default: return 32'h0001_0000;
				endcase
			end
		endcase
	endfunction

	task automatic send_item(input logic [FIELD_W-1:0] op, input logic [FIELD_W-1:0] row,
		input logic [FIELD_W-1:0] col, input logic [VAL_W-1:0] value);
		while (tx_gaps && $urandom_range(99) < 31) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'b0, value, col, row};
		do @(posedge clk); while (!s_tready);
		case (op)
			MODE_LOAD_A, MODE_LOAD_B: loads_sent++;
			MODE_START: starts_sent++;
			default: ignored_sent++;
		endcase
	endtask

	// drop valid, wait for every product, then let the pipeline drain
	task automatic settle(input int extra);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_REG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic write_dims(input logic [DIM_REG_W-1:0] r, input logic [DIM_REG_W-1:0] k,
		input logic [DIM_REG_W-1:0] c, input bit with_spare);
		if (with_spare) begin
			write_reg(CFG_SPARE, DIM_REG_W'($urandom));
		end
		write_reg(CFG_ROWS_A, r);
		write_reg(CFG_INNER_SIZE, k);
		write_reg(CFG_COLS_B, c);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_LOAD_A;
		cfg_valid = 1'b0;
		cfg_index = CFG_ROWS_A;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill both stores so no multiply ever reads an unwritten element
		for (int r = 0; r < DEF_MAX_DIM; r++) begin
			for (int c = 0; c < DEF_MAX_DIM; c++) begin
				send_item(MODE_LOAD_A, 2'(r), 2'(c), elem_value());
				send_item(MODE_LOAD_B, 2'(r), 2'(c), elem_value());
			end
		end

		// full 4x4 product with the dimensions left by reset
		send_item(MODE_START, 2'($urandom), 2'($urandom), $urandom);
		settle(SETTLE_CYCLES);

		// positive and negative saturation, plus an ignored item with every bit set
		write_dims(3'd2, 3'd4, 3'd1, 1'b0);
		for (int k = 0; k < DEF_MAX_DIM; k++) begin
			send_item(MODE_LOAD_A, 2'd0, 2'(k), SAT_MAX);
			send_item(MODE_LOAD_A, 2'd1, 2'(k), SAT_MIN);
			send_item(MODE_LOAD_B, 2'(k), 2'd0, SAT_MAX);
		end
		send_item(MODE_UNUSED, 2'b11, 2'b11, '1);
		send_item(MODE_START, 2'b11, 2'b11, '1);
		settle(SETTLE_CYCLES);

		// zero dimensions act as one; smallest negative product truncates to -1
		write_dims(3'd0, 3'd0, 3'd0, 1'b0);
		send_item(MODE_LOAD_A, 2'd0, 2'd0, 32'd1);
		send_item(MODE_LOAD_B, 2'd0, 2'd0, '1);
		send_item(MODE_START, 2'd0, 2'd0, '0);
		settle(SETTLE_CYCLES);

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin dim_r = 3'd7; dim_k = 3'd7; dim_c = 3'd7; end
				1: begin dim_r = 3'd1; dim_k = 3'd1; dim_c = 3'd1; end
				2: begin dim_r = 3'd0; dim_k = 3'd5; dim_c = 3'd6; end
				3: begin dim_r = 3'd4; dim_k = 3'd1; dim_c = 3'd4; end
				default: begin
					dim_r = 3'($urandom);
					dim_k = 3'($urandom);
					dim_c = 3'($urandom);
				end
			endcase
			write_dims(dim_r, dim_k, dim_c, (p % 4) == 2);
			if (p == HOLD_PHASE) begin
				hold_req <= 1'b1;
			end
			if (p == STEADY_PHASE) begin
				tx_gaps = 1'b0;
				rx_gaps <= 1'b0;
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (p == HOLD_PHASE && sent < 4) begin
					mode = MODE_START;
				end else if (pick < 40) begin
					mode = MODE_LOAD_A;
				end else if (pick < 80) begin
					mode = MODE_LOAD_B;
				end else if (pick < 94) begin
					mode = MODE_START;
				end else begin
					mode = MODE_UNUSED;
				end
				send_item(mode, 2'($urandom), 2'($urandom), elem_value());
				if (mode != MODE_UNUSED) begin
					sent++;
				end
			end
			settle(SETTLE_CYCLES);
			hold_req <= 1'b0;
			tx_gaps = 1'b1;
			rx_gaps <= 1'b1;
		end

		settle(DRAIN_CYCLES);
		$display("covered %0d loads, %0d starts and %0d ignored items", loads_sent, starts_sent,
			ignored_sent);
		$display("checked %0d product elements over %0d dimension settings", products_checked,
			settings_used + 1);
		if (errors == 0 && outstanding == 0) begin
			$display("matrix_multiply_top_test OK");
		end else begin
			$display("matrix_multiply_top_test NOT OK");
		end
		$finish;
	end

endmodule
